// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge except while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/hff_pkg.sv
package hff_pkg;

  localparam int LEN_W = 7;
  localparam int MAX_FIELD_DEF = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int NIBBLES = 8;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef struct packed {
    logic [31:0]       value;
    logic [6:0]        width;
    logic signed [7:0] precision;
    logic              left_justify;
    logic              zero_pad;
    logic              upper_case;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic [6:0] total_length;
  } out_item_t;

  typedef struct packed {
    logic [31:0]      value;
    logic [LEN_W-1:0] pad_len;
    logic [LEN_W-1:0] body_len;
    logic [LEN_W-1:0] total;
    logic             left_justify;
    logic             zero_pad;
    logic             upper_case;
    logic             blank;
  } desc_t;

endpackage

// File: rtl/hff_front.sv
module hff_front #(
  parameter int MAX_FIELD = hff_pkg::MAX_FIELD_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  hff_pkg::in_item_t item,
  output logic             busy,
  input  logic             q_full,
  output logic             push,
  output hff_pkg::desc_t   desc
);

  localparam logic [hff_pkg::LEN_W-1:0] MaxLen = hff_pkg::LEN_W'(MAX_FIELD);

  hff_pkg::in_item_t      held;
  logic                   held_valid;
  logic                   held_valid_next;
  logic                   consumed;
  logic                   drop;
  logic [hff_pkg::LEN_W-1:0] width_c;
  logic [hff_pkg::LEN_W-1:0] prec_c;
  logic                   prec_none;
  logic [hff_pkg::LEN_W-1:0] digits;
  logic [hff_pkg::LEN_W-1:0] body;
  logic [hff_pkg::LEN_W-1:0] pad;
  logic                   blank;

  always_comb begin
    width_c = (held.width > MaxLen) ? MaxLen : held.width;
    prec_none = held.precision[7];
    prec_c = (held.precision[6:0] > MaxLen) ? MaxLen : held.precision[6:0];
    digits = hff_pkg::LEN_W'(1);
    for (int i = 1; i < hff_pkg::NIBBLES; i++) begin
      if (held.value[i*4 +: 4] != 4'd0) begin
        digits = hff_pkg::LEN_W'(i + 1);
      end
    end
    body = (!prec_none && (prec_c > digits)) ? prec_c : digits;
    pad = (width_c > body) ? (width_c - body) : '0;
    blank = !prec_none && (prec_c == '0) && (held.value == 32'd0);
    drop = blank && (width_c == '0);
  end

  always_comb begin
    desc.value = held.value;
    desc.pad_len = pad;
    desc.body_len = body;
    desc.total = pad + body;
    desc.left_justify = held.left_justify;
    desc.zero_pad = held.zero_pad;
    desc.upper_case = held.upper_case;
    desc.blank = blank;
  end

  assign consumed = held_valid && (drop || !q_full);
  assign push = held_valid && !drop && !q_full;
  assign busy = held_valid && !consumed;

  always_comb begin
    held_valid_next = held_valid;
    if (start && !busy) begin
      held_valid_next = 1'b1;
    end else if (consumed) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      held <= item;
    end
  end

endmodule

// File: rtl/hff_queue.sv
module hff_queue #(
  parameter int DEPTH = hff_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hff_pkg::desc_t wdata,
  input  logic           pop,
  output hff_pkg::desc_t rdata,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hff_pkg::desc_t     entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

// File: rtl/hff_back.sv
module hff_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  hff_pkg::desc_t     q_data,
  output logic               pop,
  output logic               strobe,
  output hff_pkg::out_item_t result
);

  hff_pkg::desc_t            cur;
  logic                      active;
  logic [hff_pkg::LEN_W-1:0] pos;
  logic                      finishing;
  logic                      load;
  logic                      in_body;
  logic [hff_pkg::LEN_W-1:0] body_pos;
  logic [hff_pkg::LEN_W-1:0] nib_idx;
  logic [3:0]                nib;
  logic [7:0]                hex_char;
  logic [7:0]                pad_char;
  logic [7:0]                ch;
  logic                      is_last;

  assign is_last = (pos == cur.total - hff_pkg::LEN_W'(1));
  assign finishing = active && is_last;
  assign load = (!active || finishing) && !q_empty;
  assign pop = load;

  always_comb begin
    in_body = cur.left_justify ? (pos < cur.body_len) : (pos >= cur.pad_len);
    body_pos = cur.left_justify ? pos : (pos - cur.pad_len);
    nib_idx = cur.body_len - hff_pkg::LEN_W'(1) - body_pos;
    nib = (nib_idx < hff_pkg::LEN_W'(hff_pkg::NIBBLES))
        ? 4'(cur.value >> {nib_idx[2:0], 2'b00}) : 4'd0;
    if (nib <= 4'd9) begin
      hex_char = hff_pkg::CH_ZERO + {4'd0, nib};
    end else begin
      hex_char = (cur.upper_case ? hff_pkg::CH_UPPER_A : hff_pkg::CH_LOWER_A)
               + {4'd0, nib} - 8'd10;
    end
    pad_char = cur.zero_pad ? hff_pkg::CH_ZERO : hff_pkg::CH_SPACE;
    if (!in_body) begin
      ch = pad_char;
    end else if (cur.blank) begin
      ch = hff_pkg::CH_SPACE;
    end else begin
      ch = hex_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (load) begin
        active <= 1'b1;
      end else if (finishing) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
      pos <= '0;
    end else if (active) begin
      pos <= pos + hff_pkg::LEN_W'(1);
    end
    result.character <= ch;
    result.last <= is_last;
    result.total_length <= is_last ? cur.total : '0;
  end

endmodule

// File: rtl/hex_field_formatter.sv
// Formats a 32-bit value as a hexadecimal text field and streams it out one
// ASCII character per clock cycle on result, marked by strobe, with last and
// total_length on the final character. An item has as many characters as
// the larger of the width and the digit or precision count, at most
// MAX_FIELD; an item that prints nothing is dropped and gives no output. An
// input register and a two-entry descriptor queue sit in front of the
// character generator, so new items are taken while earlier ones stream.
// Output cannot be stalled; busy rises only while both queue entries and the
// input register are taken. An item passes the input register, a queue
// entry and the register cur before its first character is put on result.
module hex_field_formatter #(
  parameter int MAX_FIELD = hff_pkg::MAX_FIELD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  hff_pkg::in_item_t  item,
  output logic               busy,
  output logic               strobe,
  output hff_pkg::out_item_t result
);

  hff_pkg::desc_t push_desc;
  hff_pkg::desc_t head_desc;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  hff_front #(
    .MAX_FIELD(MAX_FIELD)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .q_full(q_full),
    .push  (push),
    .desc  (push_desc)
  );

  hff_queue #(
    .DEPTH(hff_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(push_desc),
    .pop  (pop),
    .rdata(head_desc),
    .full (q_full),
    .empty(q_empty)
  );

  hff_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_data (head_desc),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

// File: rtl/hff_checker.sv
`include "assert_macros.svh"

module hff_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               strobe,
  input hff_pkg::out_item_t result
);

  localparam logic [hff_pkg::LEN_W-1:0] MaxLen = hff_pkg::LEN_W'(hff_pkg::MAX_FIELD_DEF);

  logic [7:0]                ch;
  logic                      ch_ok;
  logic                      is_last;
  logic [hff_pkg::LEN_W-1:0] len;

  assign ch = result.character;
  assign is_last = result.last;
  assign len = result.total_length;
  assign ch_ok = ch inside {[hff_pkg::CH_ZERO : hff_pkg::CH_ZERO + 8'd9],
                            [hff_pkg::CH_LOWER_A : hff_pkg::CH_LOWER_A + 8'd5],
                            [hff_pkg::CH_UPPER_A : hff_pkg::CH_UPPER_A + 8'd5],
                            hff_pkg::CH_SPACE};

  `ASSERT_CLK_ALWAYS(a_reset_quiet, rst |=> (!strobe && !busy), "output or busy after reset")
  `ASSERT_CLK(a_len_only_last, (strobe && !is_last) |-> (len == '0), "length on inner character")
  `ASSERT_CLK(a_len_range, (strobe && is_last) |-> (len != '0 && len <= MaxLen), "bad final length")
  `ASSERT_CLK(a_char_set, strobe |-> ch_ok, "character outside hex set")

endmodule

bind hex_field_formatter hff_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .busy  (busy),
  .strobe(strobe),
  .result(result)
);
